/* hdl/ealu_pkg.sv */
// Shared types and constants for the eight-bit ALU with flags.
// Used by the channel interfaces, the datapath, the top level and the checker.
package ealu_pkg;

  typedef enum logic [4:0] {
    ACT_ADD       = 5'd0,
    ACT_ADC       = 5'd1,
    ACT_SUB       = 5'd2,
    ACT_SBC       = 5'd3,
    ACT_AND       = 5'd4,
    ACT_XOR       = 5'd5,
    ACT_OR        = 5'd6,
    ACT_CP        = 5'd7,
    ACT_INC       = 5'd8,
    ACT_DEC       = 5'd9,
    ACT_DAA       = 5'd10,
    ACT_RLCA      = 5'd11,
    ACT_RLA       = 5'd12,
    ACT_RRCA      = 5'd13,
    ACT_RRA       = 5'd14,
    ACT_RLC       = 5'd15,
    ACT_RL        = 5'd16,
    ACT_RRC       = 5'd17,
    ACT_RR        = 5'd18,
    ACT_SLA       = 5'd19,
    ACT_SRA       = 5'd20,
    ACT_SRL       = 5'd21,
    ACT_SWAP      = 5'd22,
    ACT_BIT       = 5'd23,
    ACT_ADD16     = 5'd24,
    ACT_SP_OFFSET = 5'd25,
    ACT_LOAD      = 5'd26
  } action_e;

  // Flag register, Z in the top bit and C in the bottom bit.
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [4:0]        action;
    logic [7:0]        operand_byte;
    logic [7:0]        bit_mask;
    logic [15:0]       wide_first;
    logic [15:0]       wide_second;
    logic signed [7:0] signed_offset;
    logic [3:0]        flags_load;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  byte_result;
    logic [7:0]  accumulator;
    logic        zero_flag;
    logic        subtract_flag;
    logic        half_carry_flag;
    logic        carry_flag;
    logic [15:0] wide_result;
  } out_item_t;

  // Decimal adjust: upper limit of a valid BCD byte and the two corrections.
  localparam logic [7:0] DAA_LIMIT  = 8'h99;
  localparam logic [3:0] DAA_DIGIT  = 4'h9;
  localparam logic [7:0] DAA_ADJ_HI = 8'h60;
  localparam logic [7:0] DAA_ADJ_LO = 8'h06;

endpackage

/* hdl/ealu_if.sv */
// Valid/ready channel interfaces for the ALU request and result streams.
// Depends on ealu_pkg for the payload types.
interface ealu_req_if;
  import ealu_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ealu_rsp_if;
  import ealu_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/eight_bit_alu_with_flags.sv */
// Top level of the eight-bit ALU with Z N H C flags: input register, datapath,
// result register, accumulator and flag state. Depends on ealu_pkg, ealu_if, ealu_core.
//
// The block takes one operation per transfer on req_i and returns exactly one
// result per operation on rsp_o, in order. Throughput is one operation per
// clock while rsp_o keeps ready high: the datapath between the input register
// and the result register is a single pass of short add, logic and shift
// logic, and the accumulator and flags are written on the same edge that loads
// the result register, so an operation that depends on the previous one can
// follow in the very next cycle. A request is captured in the input register
// on its transfer, and its result is loaded into the result register when the
// input stage advances. While a result waits on rsp_o the input register
// still takes one more request; ready on req_i drops only when both registers
// are full. Reset clears the accumulator and all four flags.
module eight_bit_alu_with_flags (
  input  logic            clk_i,
  input  logic            rst_ni,
  ealu_req_if.sink        req_i,
  ealu_rsp_if.source      rsp_o
);
  import ealu_pkg::*;

  // Input stage
  in_item_t  in_q;
  logic      in_vld_q;
  logic      in_vld_d;

  // Result stage
  out_item_t out_q;
  out_item_t out_d;
  logic      out_vld_q;
  logic      out_vld_d;

  // Architectural state
  logic [7:0] acc_q;
  logic [7:0] acc_d;
  flags_t     flg_q;
  flags_t     flg_d;

  logic advance;
  logic in_xfer;

  // Advance the input stage when it holds a request and the result register is free or drains now.
  assign advance = in_vld_q & (~out_vld_q | rsp_o.ready);
  assign req_i.ready = ~in_vld_q | advance;
  assign in_xfer = req_i.valid & req_i.ready;

  ealu_core u_core (
    .item_i   (in_q),
    .acc_i    (acc_q),
    .flags_i  (flg_q),
    .result_o (out_d)
  );

  // Next state follows the result being registered.
  always_comb begin
    acc_d     = acc_q;
    flg_d     = flg_q;
    in_vld_d  = in_vld_q;
    out_vld_d = out_vld_q;
    if (advance) begin
      acc_d = out_d.accumulator;
      flg_d = '{z: out_d.zero_flag, n: out_d.subtract_flag,
                h: out_d.half_carry_flag, c: out_d.carry_flag};
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (in_xfer) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      acc_q     <= '0;
      flg_q     <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      acc_q     <= acc_d;
      flg_q     <= flg_d;
    end
  end

  // Payload registers: capture on transfer, load result on advance.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= req_i.payload;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign rsp_o.valid   = out_vld_q;
  assign rsp_o.payload = out_q;

endmodule

/* hdl/ealu_core.sv */
// Single-pass ALU datapath: one request plus the current accumulator and flags
// in, one result item out. Depends on ealu_pkg.
module ealu_core (
  input  ealu_pkg::in_item_t  item_i,
  input  logic [7:0]          acc_i,
  input  ealu_pkg::flags_t    flags_i,
  output ealu_pkg::out_item_t result_o
);
  import ealu_pkg::*;

  action_e     act;
  logic [7:0]  v;
  logic [7:0]  off_u;
  logic        cin_add;
  logic        cin_sub;
  logic [8:0]  sum9;
  logic [4:0]  sum5;
  logic [8:0]  dif9;
  logic [4:0]  dif5;
  logic [16:0] s17;
  logic [12:0] s13;
  logic [15:0] sp_sum;
  logic [4:0]  sp5;
  logic [8:0]  sp9;
  logic        daa_hi;
  logic        daa_lo;
  logic [7:0]  daa_a;
  logic [7:0]  a_n;
  logic [7:0]  r;
  logic        byte_op;
  logic [15:0] wide;
  flags_t      f;

  assign act   = action_e'(item_i.action);
  assign v     = item_i.operand_byte;
  assign off_u = item_i.signed_offset;

  // Shared adders for the eight-bit arithmetic.
  assign cin_add = (act == ACT_ADC) & flags_i.c;
  assign cin_sub = (act == ACT_SBC) & flags_i.c;
  assign sum9 = {1'b0, acc_i} + {1'b0, v} + {8'd0, cin_add};
  assign sum5 = {1'b0, acc_i[3:0]} + {1'b0, v[3:0]} + {4'd0, cin_add};
  assign dif9 = {1'b0, acc_i} - {1'b0, v} - {8'd0, cin_sub};
  assign dif5 = {1'b0, acc_i[3:0]} - {1'b0, v[3:0]} - {4'd0, cin_sub};

  // Sixteen-bit adds.
  assign s17    = {1'b0, item_i.wide_first} + {1'b0, item_i.wide_second};
  assign s13    = {1'b0, item_i.wide_first[11:0]} + {1'b0, item_i.wide_second[11:0]};
  assign sp_sum = item_i.wide_first + {{8{off_u[7]}}, off_u};
  assign sp5    = {1'b0, item_i.wide_first[3:0]} + {1'b0, off_u[3:0]};
  assign sp9    = {1'b0, item_i.wide_first[7:0]} + {1'b0, off_u};

  // Decimal adjust; the high correction leaves the low digit alone.
  assign daa_hi = flags_i.c | (acc_i > DAA_LIMIT);
  assign daa_lo = flags_i.h | (acc_i[3:0] > DAA_DIGIT);
  always_comb begin
    if (!flags_i.n) begin
      daa_a = acc_i + (daa_hi ? DAA_ADJ_HI : 8'd0) + (daa_lo ? DAA_ADJ_LO : 8'd0);
    end else begin
      daa_a = acc_i - (flags_i.c ? DAA_ADJ_HI : 8'd0) - (flags_i.h ? DAA_ADJ_LO : 8'd0);
    end
  end

  always_comb begin
    a_n     = acc_i;
    f       = flags_i;
    r       = acc_i;
    byte_op = 1'b0;
    wide    = 16'd0;
    case (act)
      ACT_ADD, ACT_ADC: begin
        a_n = sum9[7:0];
        f   = '{z: (sum9[7:0] == 8'd0), n: 1'b0, h: sum5[4], c: sum9[8]};
      end
      ACT_SUB, ACT_SBC: begin
        a_n = dif9[7:0];
        f   = '{z: (dif9[7:0] == 8'd0), n: 1'b1, h: dif5[4], c: dif9[8]};
      end
      ACT_CP: begin
        f = '{z: (dif9[7:0] == 8'd0), n: 1'b1, h: dif5[4], c: dif9[8]};
      end
      ACT_AND: begin
        a_n = acc_i & v;
        f   = '{z: ((acc_i & v) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      ACT_XOR: begin
        a_n = acc_i ^ v;
        f   = '{z: ((acc_i ^ v) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      ACT_OR: begin
        a_n = acc_i | v;
        f   = '{z: ((acc_i | v) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      ACT_INC: begin
        r       = v + 8'd1;
        byte_op = 1'b1;
        f       = '{z: (v == 8'hFF), n: 1'b0, h: (v[3:0] == 4'hF), c: flags_i.c};
      end
      ACT_DEC: begin
        r       = v - 8'd1;
        byte_op = 1'b1;
        f       = '{z: (v == 8'h01), n: 1'b1, h: (v[3:0] == 4'h0), c: flags_i.c};
      end
      ACT_DAA: begin
        a_n = daa_a;
        f   = '{z: (daa_a == 8'd0), n: flags_i.n, h: 1'b0,
                c: flags_i.n ? flags_i.c : daa_hi};
      end
      ACT_RLCA: begin
        a_n = {acc_i[6:0], acc_i[7]};
        f   = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc_i[7]};
      end
      ACT_RLA: begin
        a_n = {acc_i[6:0], flags_i.c};
        f   = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc_i[7]};
      end
      ACT_RRCA: begin
        a_n = {acc_i[0], acc_i[7:1]};
        f   = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc_i[0]};
      end
      ACT_RRA: begin
        a_n = {flags_i.c, acc_i[7:1]};
        f   = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc_i[0]};
      end
      ACT_RLC: begin
        r = {v[6:0], v[7]};
        byte_op = 1'b1;
        f = '{z: (v == 8'd0), n: 1'b0, h: 1'b0, c: v[7]};
      end
      ACT_RL: begin
        r = {v[6:0], flags_i.c};
        byte_op = 1'b1;
        f = '{z: ({v[6:0], flags_i.c} == 8'd0), n: 1'b0, h: 1'b0, c: v[7]};
      end
      ACT_RRC: begin
        r = {v[0], v[7:1]};
        byte_op = 1'b1;
        f = '{z: (v == 8'd0), n: 1'b0, h: 1'b0, c: v[0]};
      end
      ACT_RR: begin
        r = {flags_i.c, v[7:1]};
        byte_op = 1'b1;
        f = '{z: ({flags_i.c, v[7:1]} == 8'd0), n: 1'b0, h: 1'b0, c: v[0]};
      end
      ACT_SLA: begin
        r = {v[6:0], 1'b0};
        byte_op = 1'b1;
        f = '{z: (v[6:0] == 7'd0), n: 1'b0, h: 1'b0, c: v[7]};
      end
      ACT_SRA: begin
        r = {v[7], v[7:1]};
        byte_op = 1'b1;
        f = '{z: (v[7:1] == 7'd0), n: 1'b0, h: 1'b0, c: v[0]};
      end
      ACT_SRL: begin
        r = {1'b0, v[7:1]};
        byte_op = 1'b1;
        f = '{z: (v[7:1] == 7'd0), n: 1'b0, h: 1'b0, c: v[0]};
      end
      ACT_SWAP: begin
        r = {v[3:0], v[7:4]};
        byte_op = 1'b1;
        f = '{z: (v == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      ACT_BIT: begin
        f = '{z: ((v & item_i.bit_mask) == 8'd0), n: 1'b0, h: 1'b1, c: flags_i.c};
      end
      ACT_ADD16: begin
        wide = s17[15:0];
        f    = '{z: flags_i.z, n: 1'b0, h: s13[12], c: s17[16]};
      end
      ACT_SP_OFFSET: begin
        wide = sp_sum;
        f    = '{z: 1'b0, n: 1'b0, h: sp5[4], c: sp9[8]};
      end
      ACT_LOAD: begin
        a_n = v;
        f   = flags_t'(item_i.flags_load);
      end
      default: begin
        // unused codes: hold state
        a_n = acc_i;
      end
    endcase
  end

  assign result_o.byte_result     = byte_op ? r : a_n;
  assign result_o.accumulator     = a_n;
  assign result_o.zero_flag       = f.z;
  assign result_o.subtract_flag   = f.n;
  assign result_o.half_carry_flag = f.h;
  assign result_o.carry_flag      = f.c;
  assign result_o.wide_result     = wide;

endmodule

/* hdl/ealu_chk.sv */
// Port-level checker for the eight-bit ALU, bound to the top level.
// Depends on ealu_pkg for the result payload type.
module ealu_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input ealu_pkg::out_item_t out_payload_i
);
  import ealu_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("result changed while stalled");

  // A draining output always frees the input side.
  a_ready_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input not ready while output drains");

  // A new result follows an input transfer that passed through the input register.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without matching request");

  // Only the sixteen-bit adds give a wide result; they clear N and write no byte.
  a_wide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_payload_i.wide_result != 16'd0) |->
      !out_payload_i.subtract_flag &&
      (out_payload_i.byte_result == out_payload_i.accumulator))
    else $error("wide result with inconsistent byte fields");

endmodule

bind eight_bit_alu_with_flags ealu_chk u_ealu_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req_i.valid),
  .in_ready_i    (req_i.ready),
  .out_valid_i   (rsp_o.valid),
  .out_ready_i   (rsp_o.ready),
  .out_payload_i (rsp_o.payload)
);
